// ===== design/sbox_pkg.sv =====
package sbox_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = 6;
    localparam int CNT_W       = 7;
    localparam int COORD_W     = 32;
    localparam int BEAD_W      = 21;
    localparam int BOX_W       = 34;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        STS_INSERTED = 3'd0,
        STS_MATCH    = 3'd1,
        STS_NOMATCH  = 3'd2,
        STS_BADARG   = 3'd3,
        STS_FULL     = 3'd4,
        STS_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    // box bounds in half-micrometres
    typedef struct packed {
        logic signed [BOX_W-1:0] min_x;
        logic signed [BOX_W-1:0] max_x;
        logic signed [BOX_W-1:0] min_y;
        logic signed [BOX_W-1:0] max_y;
        logic signed [BOX_W-1:0] min_z;
        logic signed [BOX_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_tbl_req;

endpackage

// ===== design/sbox_if.sv =====
interface sbox_in_if;
    import sbox_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [1:0]                op;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic signed [COORD_W-1:0] second_z;
    logic signed [BEAD_W-1:0]  bead_width;
    logic signed [BEAD_W-1:0]  bead_height;

    modport source (
        output valid, op, first_x, first_y, first_z, second_x, second_y, second_z,
               bead_width, bead_height,
        input  ready
    );
    modport sink (
        input  valid, op, first_x, first_y, first_z, second_x, second_y, second_z,
               bead_width, bead_height,
        output ready
    );
endinterface

interface sbox_out_if;
    import sbox_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] entry_index;
    logic [2:0]       status;
    logic             last;
    logic [CNT_W-1:0] match_count;

    modport source (
        output valid, entry_index, status, last, match_count,
        input  ready
    );
    modport sink (
        input  valid, entry_index, status, last, match_count,
        output ready
    );
endinterface

// ===== design/sbox_table.sv =====
module sbox_table (
    input  logic              i_clk,
    input  sbox_pkg::t_tbl_req i_req,
    input  sbox_pkg::t_box    i_wdata,
    output sbox_pkg::t_box    o_rdata
);
    import sbox_pkg::*;

    t_box r_mem [TABLE_DEPTH];
    t_box r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sbox_cmp.sv =====
module sbox_cmp (
    input  sbox_pkg::t_box i_query,
    input  sbox_pkg::t_box i_entry,
    output logic           o_hit
);
    import sbox_pkg::*;

    logic hit_x;
    logic hit_y;
    logic hit_z;

    // closed ranges: touching boxes count as overlapping
    assign hit_x = (i_query.min_x <= i_entry.max_x) && (i_query.max_x >= i_entry.min_x);
    assign hit_y = (i_query.min_y <= i_entry.max_y) && (i_query.max_y >= i_entry.min_y);
    assign hit_z = (i_query.min_z <= i_entry.max_z) && (i_query.max_z >= i_entry.min_z);
    assign o_hit = hit_x && hit_y && hit_z;

endmodule

// ===== design/segment_box_overlap_query.sv =====
// Bounding box table for deposited segments with an overlap query.
// Input channel i_in carries one command per transfer: insert a segment
// (op 0), query a box (op 1) or clear the table (op 2). Output channel o_out
// carries the results; every command answers exactly one result except a
// query with matches, which answers one result per matching entry in
// ascending index order, last set on the final one.
// Insert, clear and rejected commands: the command is registered, then decoded
// once the output register is free, which loads the result and returns to idle.
// Query: decode and read entry 0, then one stored entry compared per cycle by
// the shared overlap comparator while the scan is not held by a stalled output,
// then a flush state that issues the final match.
// One command is in flight at a time; i_in.ready is high only when idle, but
// a finished result may still sit in the output register while the next
// command is taken.
// When o_out stalls, the scan holds on the next match until the output
// register frees up; nothing is dropped.
// Reset (i_rst_n low at a clock edge) empties the table and drops any
// pending result; the box memory itself is not cleared.
module segment_box_overlap_query (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sbox_in_if.sink   i_in,
    sbox_out_if.source o_out
);
    import sbox_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // captured command
    logic [1:0]                r_op;
    logic signed [COORD_W-1:0] r_fx, r_fy, r_fz, r_sx, r_sy, r_sz;
    logic signed [BEAD_W-1:0]  r_w, r_h;

    // output register
    logic             r_ov, n_ov;
    logic [IDX_W-1:0] r_o_idx, n_o_idx;
    t_status          r_o_sts, n_o_sts;
    logic             r_o_last, n_o_last;
    logic [CNT_W-1:0] r_o_cnt, n_o_cnt;

    // scan state: one match held back until it is known whether it is the last
    logic             r_pv, n_pv;
    logic [IDX_W-1:0] r_pidx, n_pidx;
    logic [CNT_W-1:0] r_pcnt, n_pcnt;
    logic [CNT_W-1:0] r_mcnt, n_mcnt;
    logic [IDX_W-1:0] r_cidx, n_cidx;

    t_tbl_req tbl_req;
    t_box     ins_box;
    t_box     qry_box;
    t_box     tbl_rdata;
    logic     hit;
    logic     out_free;
    logic     accept;
    logic     bad_bead;
    logic     inverted;
    logic     last_entry;
    logic signed [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

    sbox_table u_table (
        .i_clk   (i_clk),
        .i_req   (tbl_req),
        .i_wdata (ins_box),
        .o_rdata (tbl_rdata)
    );

    sbox_cmp u_cmp (
        .i_query (qry_box),
        .i_entry (tbl_rdata),
        .o_hit   (hit)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    assign i_in.ready        = (r_state == ST_IDLE);
    assign o_out.valid       = r_ov;
    assign o_out.entry_index = r_o_idx;
    assign o_out.status      = r_o_sts;
    assign o_out.last        = r_o_last;
    assign o_out.match_count = r_o_cnt;

    // insert box: xy widened by the bead width (half-width in half-um), z down by 2h
    always_comb begin
        lo_x = (r_fx < r_sx) ? r_fx : r_sx;
        hi_x = (r_fx < r_sx) ? r_sx : r_fx;
        lo_y = (r_fy < r_sy) ? r_fy : r_sy;
        hi_y = (r_fy < r_sy) ? r_sy : r_fy;
        lo_z = (r_fz < r_sz) ? r_fz : r_sz;
        hi_z = (r_fz < r_sz) ? r_sz : r_fz;
        ins_box.min_x = {lo_x[COORD_W-1], lo_x, 1'b0}
                      - {{(BOX_W-BEAD_W){r_w[BEAD_W-1]}}, r_w};
        ins_box.max_x = {hi_x[COORD_W-1], hi_x, 1'b0}
                      + {{(BOX_W-BEAD_W){r_w[BEAD_W-1]}}, r_w};
        ins_box.min_y = {lo_y[COORD_W-1], lo_y, 1'b0}
                      - {{(BOX_W-BEAD_W){r_w[BEAD_W-1]}}, r_w};
        ins_box.max_y = {hi_y[COORD_W-1], hi_y, 1'b0}
                      + {{(BOX_W-BEAD_W){r_w[BEAD_W-1]}}, r_w};
        ins_box.min_z = {lo_z[COORD_W-1], lo_z, 1'b0}
                      - {{(BOX_W-BEAD_W-1){r_h[BEAD_W-1]}}, r_h, 1'b0};
        ins_box.max_z = {hi_z[COORD_W-1], hi_z, 1'b0};
    end

    always_comb begin
        qry_box.min_x = {r_fx[COORD_W-1], r_fx, 1'b0};
        qry_box.max_x = {r_sx[COORD_W-1], r_sx, 1'b0};
        qry_box.min_y = {r_fy[COORD_W-1], r_fy, 1'b0};
        qry_box.max_y = {r_sy[COORD_W-1], r_sy, 1'b0};
        qry_box.min_z = {r_fz[COORD_W-1], r_fz, 1'b0};
        qry_box.max_z = {r_sz[COORD_W-1], r_sz, 1'b0};
    end

    assign bad_bead   = (r_w <= 0) || (r_h <= 0);
    assign inverted   = (r_fx > r_sx) || (r_fy > r_sy) || (r_fz > r_sz);
    assign last_entry = ((CNT_W'(r_cidx) + CNT_W'(1)) == r_count);

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ov     = r_ov;
        n_o_idx  = r_o_idx;
        n_o_sts  = r_o_sts;
        n_o_last = r_o_last;
        n_o_cnt  = r_o_cnt;
        n_pv     = r_pv;
        n_pidx   = r_pidx;
        n_pcnt   = r_pcnt;
        n_mcnt   = r_mcnt;
        n_cidx   = r_cidx;
        tbl_req  = '0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (out_free) begin
                    n_state  = ST_IDLE;
                    n_ov     = 1'b1;
                    n_o_idx  = '0;
                    n_o_sts  = STS_BADARG;
                    n_o_last = 1'b1;
                    n_o_cnt  = '0;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (bad_bead) begin
                                n_o_sts = STS_BADARG;
                            end else if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                                n_o_sts = STS_FULL;
                            end else begin
                                tbl_req.we    = 1'b1;
                                tbl_req.waddr = r_count[IDX_W-1:0];
                                n_o_idx       = r_count[IDX_W-1:0];
                                n_o_sts       = STS_INSERTED;
                                n_count       = r_count + CNT_W'(1);
                            end
                        end
                        OP_QUERY: begin
                            if (inverted) begin
                                n_o_sts = STS_BADARG;
                            end else if (r_count == '0) begin
                                n_o_sts = STS_NOMATCH;
                            end else begin
                                // no result yet: start the scan at entry 0
                                n_ov          = r_ov && !o_out.ready;
                                tbl_req.re    = 1'b1;
                                tbl_req.raddr = '0;
                                n_cidx        = '0;
                                n_pv          = 1'b0;
                                n_mcnt        = '0;
                                n_state       = ST_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_o_sts = STS_CLEARED;
                        end
                        default: begin
                            n_o_sts = STS_BADARG;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // a new match can only push out the held one if the output is free
                if (!(hit && r_pv && !out_free)) begin
                    if (hit) begin
                        if (r_pv) begin
                            n_ov     = 1'b1;
                            n_o_idx  = r_pidx;
                            n_o_sts  = STS_MATCH;
                            n_o_last = 1'b0;
                            n_o_cnt  = r_pcnt;
                        end
                        n_pv   = 1'b1;
                        n_pidx = r_cidx;
                        n_pcnt = r_mcnt + CNT_W'(1);
                        n_mcnt = r_mcnt + CNT_W'(1);
                    end
                    if (last_entry) begin
                        n_state = ST_FLUSH;
                    end else begin
                        tbl_req.re    = 1'b1;
                        tbl_req.raddr = r_cidx + IDX_W'(1);
                        n_cidx        = r_cidx + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state  = ST_IDLE;
                    n_ov     = 1'b1;
                    n_o_last = 1'b1;
                    if (r_pv) begin
                        n_o_idx = r_pidx;
                        n_o_sts = STS_MATCH;
                        n_o_cnt = r_pcnt;
                        n_pv    = 1'b0;
                    end else begin
                        n_o_idx = '0;
                        n_o_sts = STS_NOMATCH;
                        n_o_cnt = '0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_mcnt  <= '0;
            r_cidx  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
            r_mcnt  <= n_mcnt;
            r_cidx  <= n_cidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_idx  <= n_o_idx;
        r_o_sts  <= n_o_sts;
        r_o_last <= n_o_last;
        r_o_cnt  <= n_o_cnt;
        r_pidx   <= n_pidx;
        r_pcnt   <= n_pcnt;
        if (accept) begin
            r_op <= i_in.op;
            r_fx <= i_in.first_x;
            r_fy <= i_in.first_y;
            r_fz <= i_in.first_z;
            r_sx <= i_in.second_x;
            r_sy <= i_in.second_y;
            r_sz <= i_in.second_z;
            r_w  <= i_in.bead_width;
            r_h  <= i_in.bead_height;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_count != '0) && (CNT_W'(r_cidx) < r_count)))
        else $error("scan index outside stored entries");

    a_not_last_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_last) |-> (r_o_sts == STS_MATCH))
        else $error("non-final result that is not a match");

    a_match_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_o_sts == STS_MATCH)) |-> (r_o_cnt != '0))
        else $error("match result with zero count");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pv)
        else $error("held match left over after query");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import sbox_pkg::*;

    localparam int          CLK_HALF     = 5;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_ITEMS = 350;
    localparam int          CALM_ITEMS   = 60;
    localparam int          TAIL_CYCLES  = 100;
    localparam int          LONG_HOLD    = 400;
    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int          WORLD        = 2000;
    localparam int          COORD_MAX    = 2147483647;
    localparam int          COORD_MIN    = -2147483647 - 1;
    localparam int          BEAD_MAX     = 1048575;
    localparam int          BEAD_MIN     = -1048576;
    localparam logic [1:0]  OP_UNKNOWN   = 2'd3;

    typedef struct {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [BEAD_W-1:0]  bead_width;
        logic signed [BEAD_W-1:0]  bead_height;
    } t_cmd;

    typedef struct {
        logic [IDX_W-1:0] entry_index;
        t_status          status;
        logic             last;
        logic [CNT_W-1:0] match_count;
    } t_result;

    // box table model and the queue of results still owed by the block
    class overlap_scoreboard;
        t_box        boxes [TABLE_DEPTH];
        int unsigned stored;
        t_result     expected_q [$];
        int unsigned mismatches;

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void owe(logic [IDX_W-1:0] idx, t_status st, logic lst,
                          logic [CNT_W-1:0] cnt);
            t_result r;
            r.entry_index = idx;
            r.status      = st;
            r.last        = lst;
            r.match_count = cnt;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function void note_command(t_cmd c);
            longint      lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, w, h;
            bit          inverted;
            int unsigned hits [$];
            lo_x = (c.first_x < c.second_x) ? c.first_x : c.second_x;
            hi_x = (c.first_x < c.second_x) ? c.second_x : c.first_x;
            lo_y = (c.first_y < c.second_y) ? c.first_y : c.second_y;
            hi_y = (c.first_y < c.second_y) ? c.second_y : c.first_y;
            lo_z = (c.first_z < c.second_z) ? c.first_z : c.second_z;
            hi_z = (c.first_z < c.second_z) ? c.second_z : c.first_z;
            w    = c.bead_width;
            h    = c.bead_height;
            inverted = (c.first_x > c.second_x) || (c.first_y > c.second_y) ||
                       (c.first_z > c.second_z);
            case (c.op)
                OP_INSERT: begin
                    // argument check wins over the full check
                    if (w <= 0 || h <= 0) begin
                        owe('0, STS_BADARG, 1'b1, '0);
                    end else if (stored >= TABLE_DEPTH) begin
                        owe('0, STS_FULL, 1'b1, '0);
                    end else begin
                        // half-micrometre units keep the half width exact
                        boxes[stored].min_x = BOX_W'(2 * lo_x - w);
                        boxes[stored].max_x = BOX_W'(2 * hi_x + w);
                        boxes[stored].min_y = BOX_W'(2 * lo_y - w);
                        boxes[stored].max_y = BOX_W'(2 * hi_y + w);
                        boxes[stored].min_z = BOX_W'(2 * lo_z - 2 * h);
                        boxes[stored].max_z = BOX_W'(2 * hi_z);
                        owe(IDX_W'(stored), STS_INSERTED, 1'b1, '0);
                        stored++;
                    end
                end
                OP_QUERY: begin
                    if (inverted) begin
                        owe('0, STS_BADARG, 1'b1, '0);
                    end else begin
                        // touching faces count as overlap
                        for (int i = 0; i < stored; i++) begin
                            if (2 * lo_x <= $signed(boxes[i].max_x) &&
                                2 * hi_x >= $signed(boxes[i].min_x) &&
                                2 * lo_y <= $signed(boxes[i].max_y) &&
                                2 * hi_y >= $signed(boxes[i].min_y) &&
                                2 * lo_z <= $signed(boxes[i].max_z) &&
                                2 * hi_z >= $signed(boxes[i].min_z))
                                hits.insert(hits.size(), i);
                        end
                        if (hits.size() == 0)
                            owe('0, STS_NOMATCH, 1'b1, '0);
                        foreach (hits[k])
                            owe(IDX_W'(hits[k]), STS_MATCH, k == hits.size() - 1,
                                CNT_W'(k + 1));
                    end
                end
                OP_CLEAR: begin
                    stored = 0;
                    owe('0, STS_CLEARED, 1'b1, '0);
                end
                default: begin
                    owe('0, STS_BADARG, 1'b1, '0);
                end
            endcase
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [IDX_W-1:0] idx, logic [2:0] st, logic lst,
                          logic [CNT_W-1:0] cnt);
            t_result e;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result index %0d status %0d", idx, st));
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, want %s", st, e.status.name()));
            if (idx !== e.entry_index)
                report_mismatch($sformatf("entry_index %0d, want %0d", idx, e.entry_index));
            if (lst !== e.last)
                report_mismatch($sformatf("last %0b, want %0b", lst, e.last));
            if (cnt !== e.match_count)
                report_mismatch($sformatf("match_count %0d, want %0d", cnt, e.match_count));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sbox_in_if  in_if ();
    sbox_out_if out_if ();

    segment_box_overlap_query u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    overlap_scoreboard sb = new();
    bit                idle_on      = 1'b1;
    int unsigned       hold_request = 0;
    int unsigned       cycle_count  = 0;

    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic t_cmd make_cmd(logic [1:0] op, int ax, int ay, int az,
                                      int bx, int by, int bz, int w, int h);
        t_cmd c;
        c.op          = op;
        c.first_x     = ax;
        c.first_y     = ay;
        c.first_z     = az;
        c.second_x    = bx;
        c.second_y    = by;
        c.second_z    = bz;
        c.bead_width  = BEAD_W'(w);
        c.bead_height = BEAD_W'(h);
        return c;
    endfunction

    function automatic logic signed [COORD_W-1:0] world_coord();
        return COORD_W'(int'($urandom_range(0, 2 * WORLD)) - WORLD);
    endfunction

    function automatic t_cmd rand_insert();
        t_cmd c;
        c.op = OP_INSERT;
        if ($urandom_range(0, 7) == 0) begin
            c.first_x     = $urandom();
            c.first_y     = $urandom();
            c.first_z     = $urandom();
            c.second_x    = $urandom();
            c.second_y    = $urandom();
            c.second_z    = $urandom();
            c.bead_width  = BEAD_W'($urandom_range(1, BEAD_MAX));
            c.bead_height = BEAD_W'($urandom_range(1, BEAD_MAX));
        end else begin
            c.first_x     = world_coord();
            c.first_y     = world_coord();
            c.first_z     = world_coord();
            c.second_x    = world_coord();
            c.second_y    = world_coord();
            c.second_z    = world_coord();
            c.bead_width  = BEAD_W'($urandom_range(1, 800));
            c.bead_height = BEAD_W'($urandom_range(1, 300));
        end
        return c;
    endfunction

    function automatic t_cmd rand_query();
        t_cmd                      c;
        logic signed [COORD_W-1:0] a, b;
        logic signed [COORD_W-1:0] lo [3];
        logic signed [COORD_W-1:0] hi [3];
        bit                        wide;
        wide = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < 3; k++) begin
            if (wide) begin
                a = $urandom();
                b = $urandom();
            end else begin
                a = world_coord();
                b = a + COORD_W'($urandom_range(0, 1500));
            end
            lo[k] = (a < b) ? a : b;
            hi[k] = (a < b) ? b : a;
        end
        c.op          = OP_QUERY;
        c.first_x     = lo[0];
        c.first_y     = lo[1];
        c.first_z     = lo[2];
        c.second_x    = hi[0];
        c.second_y    = hi[1];
        c.second_z    = hi[2];
        c.bead_width  = BEAD_W'($urandom());
        c.bead_height = BEAD_W'($urandom());
        return c;
    endfunction

    function automatic t_cmd rand_noise();
        t_cmd c;
        c.op          = 2'($urandom_range(0, 3));
        c.first_x     = $urandom();
        c.first_y     = $urandom();
        c.first_z     = $urandom();
        c.second_x    = $urandom();
        c.second_y    = $urandom();
        c.second_z    = $urandom();
        c.bead_width  = BEAD_W'($urandom());
        c.bead_height = BEAD_W'($urandom());
        return c;
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send(input t_cmd c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= c.op;
        in_if.first_x     <= c.first_x;
        in_if.first_y     <= c.first_y;
        in_if.first_z     <= c.first_z;
        in_if.second_x    <= c.second_x;
        in_if.second_y    <= c.second_y;
        in_if.second_z    <= c.second_z;
        in_if.bead_width  <= c.bead_width;
        in_if.bead_height <= c.bead_height;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_command(c);
    endtask

    // result side: random stall bursts plus one long hold-off on request
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_if.ready <= 1'b1;
        forever begin
            @(posedge clk);
            if (stall_left == 0) begin
                if (hold_request > 0) begin
                    stall_left   = hold_request;
                    hold_request = 0;
                end else if (idle_on && $urandom_range(0, 4) == 0) begin
                    stall_left = $urandom_range(1, 14);
                end
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
                sb.check_result(out_if.entry_index, out_if.status, out_if.last,
                                out_if.match_count);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        t_cmd        c;
        int unsigned sent;
        int unsigned phase;
        int unsigned n;
        rst_n             <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.op          <= OP_INSERT;
        in_if.first_x     <= '0;
        in_if.first_y     <= '0;
        in_if.first_z     <= '0;
        in_if.second_x    <= '0;
        in_if.second_y    <= '0;
        in_if.second_z    <= '0;
        in_if.bead_width  <= '0;
        in_if.bead_height <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send(make_cmd(OP_QUERY, -10, -10, -10, 10, 10, 10, 5, 5));
        send(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send(make_cmd(OP_INSERT, 0, 0, 0, 100, 0, 0, 0, 200));
        send(make_cmd(OP_INSERT, 0, 0, 0, 100, 0, 0, 400, 0));
        send(make_cmd(OP_INSERT, 0, 0, 0, 100, 0, 0, BEAD_MIN, 200));
        send(make_cmd(OP_INSERT, 0, 0, 0, 100, 0, 0, 400, -1));
        send(make_cmd(OP_INSERT, 0, 0, 0, 100, 0, 0, 400, 200));
        send(make_cmd(OP_INSERT, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, COORD_MAX, BEAD_MAX, BEAD_MAX));
        // end point below start point, smallest legal bead
        send(make_cmd(OP_INSERT, 500, 500, 50, 400, 300, 40, 1, 1));
        // faces touching entry 0 exactly, then missing it by one micrometre
        send(make_cmd(OP_QUERY, 300, 200, 0, 400, 300, 10, 0, 0));
        send(make_cmd(OP_QUERY, 301, 200, 0, 400, 300, 10, 0, 0));
        send(make_cmd(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));
        send(make_cmd(OP_QUERY, 10, 0, 0, 9, 0, 0, 1, 1));
        send(make_cmd(OP_QUERY, 0, 10, 0, 0, 9, 0, 1, 1));
        send(make_cmd(OP_QUERY, 0, 0, COORD_MAX, 0, 0, COORD_MIN, 1, 1));
        c    = rand_noise();
        c.op = OP_UNKNOWN;
        send(c);
        send(make_cmd(OP_QUERY, -1000, -1000, -1000, 1000, 1000, 1000, BEAD_MIN, 0));
        send(make_cmd(OP_CLEAR, -1, -1, -1, -1, -1, -1, -1, -1));
        send(make_cmd(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN,
                      COORD_MAX, COORD_MAX, COORD_MAX, 0, 0));

        // random part: build the table, query it, sprinkle noise
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            if (phase == 0 || $urandom_range(0, 3) == 0) begin
                send(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
                sent++;
            end
            if (phase == 2 || phase == 7) begin
                // fill up, then overflow; the second time the result side holds off
                if (phase == 7)
                    hold_request = LONG_HOLD;
                while (sb.stored < TABLE_DEPTH) begin
                    send(rand_insert());
                    sent++;
                end
                send(rand_insert());
                c             = rand_insert();
                c.bead_height = '0;
                send(c);
                send(rand_insert());
                sent += 3;
            end else begin
                n = $urandom_range(1, 10);
                repeat (n) begin
                    send(rand_insert());
                    sent++;
                end
            end
            n = $urandom_range(2, 8);
            repeat (n) begin
                send(rand_query());
                sent++;
            end
            n = $urandom_range(0, 2);
            repeat (n) begin
                send(rand_noise());
                sent++;
            end
            phase++;
        end

        in_if.valid <= 1'b0;
        idle_on = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
